/* rtl/wsdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types, codes and helpers of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  // Configuration register map (APB, 64-bit registers at 8-byte spacing)
  localparam int unsigned CfgAddrW   = 4;
  localparam int unsigned CfgDataW   = 64;
  localparam logic        REG_MAXLEN = 1'b0;   // register index, paddr[3]

  localparam logic [63:0] MAXLEN_RESET = 64'hFFFF_FFFF_FFFF_FFFF;

  // Header bit fields
  localparam logic [7:0] HDR_FIN_BIT   = 8'h80;
  localparam logic [7:0] HDR_RSV1_BIT  = 8'h40;
  localparam logic [7:0] HDR_OPC_MASK  = 8'h0F;
  localparam logic [7:0] HDR_MASK_BIT  = 8'h80;
  localparam logic [7:0] HDR_LEN_MASK  = 8'h7F;
  localparam logic [6:0] LEN_EXT16     = 7'd126;
  localparam logic [6:0] LEN_EXT64     = 7'd127;

  // Opcodes
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Message kinds as reported
  localparam logic [2:0] KIND_TEXT    = 3'd0;
  localparam logic [2:0] KIND_BINARY  = 3'd1;
  localparam logic [2:0] KIND_CLOSE   = 3'd2;
  localparam logic [2:0] KIND_PING    = 3'd3;
  localparam logic [2:0] KIND_PONG    = 3'd4;
  localparam logic [2:0] KIND_UNKNOWN = 3'd5;

  localparam logic [15:0] CLOSE_DEFAULT = 16'd1000;

  // Extension length byte counts, minus one, and the masking key byte count
  localparam logic [2:0] EXT16_LEFT = 3'd1;
  localparam logic [2:0] EXT64_LEFT = 3'd7;
  localparam logic [2:0] KEY_BYTES  = 3'd4;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        frame_end;
    logic        message_end;
    logic [2:0]  message_kind;
    logic        compressed;
    logic [15:0] close_status;
    logic        length_error;
  } wsdf_result_t;

  function automatic logic [2:0] kind_of(input logic [3:0] op);
    logic [2:0] k;
    case (op)
      OP_TEXT:   k = KIND_TEXT;
      OP_BINARY: k = KIND_BINARY;
      OP_CLOSE:  k = KIND_CLOSE;
      OP_PING:   k = KIND_PING;
      OP_PONG:   k = KIND_PONG;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

/* rtl/wsdf_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_cfg_regs
// APB register file holding the maximum frame payload length.
// ----------------------------------------------------------------------------
module wsdf_cfg_regs import wsdf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output logic [63:0]         max_len_o
);

  logic [63:0] max_len_q;
  logic        wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel & penable & pwrite & (paddr[3] == REG_MAXLEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAXLEN_RESET;
    end else if (wr_hit) begin
      max_len_q <= pwdata;
    end
  end

  // Low address bits are ignored; anything past the register reads zero
  assign prdata    = (paddr[3] == REG_MAXLEN) ? max_len_q : '0;
  assign max_len_o = max_len_q;

endmodule

/* rtl/wsdf_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_parser
// Header parse, payload unmask and message tracking, one byte per accept.
// ----------------------------------------------------------------------------
module wsdf_parser import wsdf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  logic [7:0]   rx_byte_i,
  input  logic [63:0]  max_len_i,
  output logic         res_valid_o,
  output wsdf_result_t res_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  len_left_q, len_left_d;
  logic [2:0]  key_left_q, key_left_d;
  logic [63:0] remain_q, remain_d;
  logic [31:0] key_q, key_d;
  logic        masked_q, masked_d;
  logic [1:0]  pos_q, pos_d;
  logic        final_q, final_d;
  logic        in_msg_q, in_msg_d;
  logic [3:0]  first_op_q, first_op_d;
  logic        first_comp_q, first_comp_d;
  logic [1:0]  mcount_q, mcount_d;
  logic [15:0] status_q, status_d;

  logic [6:0]  len7;
  logic        is_ext;
  logic [63:0] ext_len;
  logic [2:0]  key_left_dec;
  logic        hdr_done;
  logic [63:0] len_c;
  logic        too_big;
  logic        len_zero;
  logic [7:0]  key_byte;
  logic [7:0]  plain;
  logic [63:0] remain_dec;
  logic        last_byte;

  assign len7         = rx_byte_i[6:0] & HDR_LEN_MASK[6:0];
  assign is_ext       = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
  assign ext_len      = {remain_q[55:0], rx_byte_i};
  assign key_left_dec = key_left_q - 3'd1;

  // Header completes on the last length byte (unmasked) or last key byte
  always_comb begin
    hdr_done = 1'b0;
    len_c    = remain_q;
    case (phase_q)
      PH_HDR1: begin
        hdr_done = !is_ext && ((rx_byte_i & HDR_MASK_BIT) == 8'h00);
        len_c    = {57'd0, len7};
      end
      PH_EXTLEN: begin
        hdr_done = (len_left_q == 3'd0) && !masked_q;
        len_c    = ext_len;
      end
      PH_KEY: begin
        hdr_done = (key_left_dec == 3'd0);
        len_c    = remain_q;
      end
      default: begin
        hdr_done = 1'b0;
        len_c    = remain_q;
      end
    endcase
  end

  assign too_big    = len_c > max_len_i;
  assign len_zero   = (len_c == 64'd0);
  // key byte 0 sits in bits 31..24, so the offset is (3 - pos) * 8
  assign key_byte   = key_q[{~pos_q, 3'b000} +: 8];
  assign plain      = rx_byte_i ^ key_byte;
  assign remain_dec = remain_q - 64'd1;
  assign last_byte  = (remain_dec == 64'd0);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (hdr_done) begin
      phase_d = (too_big || len_zero) ? PH_HDR0 : PH_PAYLOAD;
    end else begin
      case (phase_q)
        PH_HDR1: begin
          phase_d = is_ext ? PH_EXTLEN : PH_KEY;
        end
        PH_EXTLEN: begin
          phase_d = (len_left_q == 3'd0) ? PH_KEY : PH_EXTLEN;
        end
        PH_KEY:     phase_d = PH_KEY;
        PH_PAYLOAD: phase_d = last_byte ? PH_HDR0 : PH_PAYLOAD;
        default:    phase_d = PH_HDR1;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    len_left_d   = len_left_q;
    key_left_d   = key_left_q;
    remain_d     = remain_q;
    key_d        = key_q;
    masked_d     = masked_q;
    pos_d        = pos_q;
    final_d      = final_q;
    in_msg_d     = in_msg_q;
    first_op_d   = first_op_q;
    first_comp_d = first_comp_q;
    mcount_d     = mcount_q;
    status_d     = status_q;
    res_valid_o  = 1'b0;
    res_o        = '0;

    case (phase_q)
      PH_HDR1: begin
        masked_d = (rx_byte_i & HDR_MASK_BIT) != 8'h00;
        key_d    = '0;
        pos_d    = '0;
        if (is_ext) begin
          remain_d   = '0;
          len_left_d = (len7 == LEN_EXT16) ? EXT16_LEFT : EXT64_LEFT;
        end else begin
          remain_d = len_c;
          if (masked_d) key_left_d = KEY_BYTES;
        end
      end
      PH_EXTLEN: begin
        remain_d = ext_len;
        if (len_left_q == 3'd0) begin
          if (masked_q) key_left_d = KEY_BYTES;
        end else begin
          len_left_d = len_left_q - 3'd1;
        end
      end
      PH_KEY: begin
        key_d      = {key_q[23:0], rx_byte_i};
        key_left_d = key_left_dec;
      end
      PH_PAYLOAD: begin
        pos_d    = pos_q + 2'd1;
        remain_d = remain_dec;
        if (mcount_q == 2'd0) begin
          status_d = {plain, 8'h00};
          mcount_d = 2'd1;
        end else if (mcount_q == 2'd1) begin
          status_d = {status_q[15:8], plain};
          mcount_d = 2'd2;
        end
        res_valid_o       = 1'b1;
        res_o.data_byte   = plain;
        res_o.data_valid  = 1'b1;
        res_o.frame_end   = last_byte;
        res_o.message_end = last_byte & final_q;
      end
      default: begin
        final_d = (rx_byte_i & HDR_FIN_BIT) != 8'h00;
        if (!in_msg_q) begin
          in_msg_d     = 1'b1;
          first_op_d   = rx_byte_i[3:0] & HDR_OPC_MASK[3:0];
          first_comp_d = (rx_byte_i & HDR_RSV1_BIT) != 8'h00;
          mcount_d     = '0;
          status_d     = CLOSE_DEFAULT;
        end
      end
    endcase

    if (hdr_done && (too_big || len_zero)) begin
      res_valid_o        = 1'b1;
      res_o.frame_end    = 1'b1;
      res_o.message_end  = too_big ? 1'b1 : final_q;
      res_o.length_error = too_big;
    end

    res_o.message_kind = kind_of(first_op_q);
    res_o.compressed   = first_comp_q;
    if (res_valid_o && res_o.message_end) begin
      in_msg_d = 1'b0;
      if (res_o.message_kind == KIND_CLOSE) begin
        res_o.close_status = (mcount_d == 2'd2) ? status_d : CLOSE_DEFAULT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR0;
      len_left_q   <= '0;
      key_left_q   <= '0;
      remain_q     <= '0;
      key_q        <= '0;
      masked_q     <= 1'b0;
      pos_q        <= '0;
      final_q      <= 1'b0;
      in_msg_q     <= 1'b0;
      first_op_q   <= '0;
      first_comp_q <= 1'b0;
      mcount_q     <= '0;
      status_q     <= CLOSE_DEFAULT;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      len_left_q   <= len_left_d;
      key_left_q   <= key_left_d;
      remain_q     <= remain_d;
      key_q        <= key_d;
      masked_q     <= masked_d;
      pos_q        <= pos_d;
      final_q      <= final_d;
      in_msg_q     <= in_msg_d;
      first_op_q   <= first_op_d;
      first_comp_q <= first_comp_d;
      mcount_q     <= mcount_d;
      status_q     <= status_d;
    end
  end

  // Key bytes are only collected for masked frames
  a_key_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_KEY) |-> masked_q)
    else $error("key phase on an unmasked frame");

  // Payload phase is never entered with nothing left to send
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (remain_q != 64'd0))
    else $error("payload phase with zero bytes remaining");

  // A frame end always returns the parser to header parsing
  a_fend_hdr0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_valid_o && res_o.frame_end) |=> (phase_q == PH_HDR0))
    else $error("frame end did not return to header parse");

  // An error result closes the message
  a_err_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_valid_o && res_o.length_error) |=> !in_msg_q)
    else $error("length error left the message open");

endmodule

/* rtl/websocket_frame_deframer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// WebSocket frame deframer: header parse, unmask, message and close status.
// ----------------------------------------------------------------------------
// One received byte is taken per clock whenever the result register is empty
// or being drained in the same cycle, so the sustained rate is one byte per
// cycle. Each byte is decoded in the cycle it is accepted and its result, if
// any, appears on the output register the next cycle;
// header bytes and key bytes produce no result except when a header completes
// with a zero length or a length above max_payload_length (APB register 0,
// byte address 0, reset all ones). Configure only while the block is idle.
module websocket_frame_deframer_unit import wsdf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  // Received bytes
  input  logic                rx_valid_i,
  output logic                rx_ready_o,
  input  logic [7:0]          rx_byte_i,
  // Results
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          data_byte_o,
  output logic                data_valid_o,
  output logic                frame_end_o,
  output logic                message_end_o,
  output logic [2:0]          message_kind_o,
  output logic                compressed_o,
  output logic [15:0]         close_status_o,
  output logic                length_error_o
);

  logic         fire;
  logic [63:0]  max_len;
  logic         res_valid;
  wsdf_result_t res;
  logic         out_valid_q;
  wsdf_result_t out_q;

  wsdf_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  assign rx_ready_o = !out_valid_q || out_ready_i;
  assign fire       = rx_valid_i && rx_ready_o;

  wsdf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .rx_byte_i   (rx_byte_i),
    .max_len_i   (max_len),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result word only when a new one is produced
  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_q.data_byte;
  assign data_valid_o   = out_q.data_valid;
  assign frame_end_o    = out_q.frame_end;
  assign message_end_o  = out_q.message_end;
  assign message_kind_o = out_q.message_kind;
  assign compressed_o   = out_q.compressed;
  assign close_status_o = out_q.close_status;
  assign length_error_o = out_q.length_error;

endmodule

/* tb/wsdf_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_stream_checker
// Watches the byte, result and configuration ports of the frame deframer,
// runs its own copy of the header parser and unmasking, and compares every
// result word field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module wsdf_stream_checker import wsdf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  input  logic                pready,
  input  logic                rx_valid_i,
  input  logic                rx_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [7:0]          data_byte_o,
  input  logic                data_valid_o,
  input  logic                frame_end_o,
  input  logic                message_end_o,
  input  logic [2:0]          message_kind_o,
  input  logic                compressed_o,
  input  logic [15:0]         close_status_o,
  input  logic                length_error_o,
  output int                  mismatches_o,
  output int                  awaited_o
);

  wsdf_result_t awaited_words [$];

  // Parser copy
  logic [63:0] max_len;
  phase_e      phase;
  logic [2:0]  len_left;
  logic [2:0]  key_left;
  logic [63:0] remaining;
  logic [31:0] key;
  logic        masked;
  logic [1:0]  mask_pos;
  logic        final_frame;
  logic        in_msg;
  logic [3:0]  first_op;
  logic        first_comp;
  logic [1:0]  msg_bytes;
  logic [15:0] status;

  task automatic clear_parser();
    max_len     = MAXLEN_RESET;
    phase       = PH_HDR0;
    len_left    = '0;
    key_left    = '0;
    remaining   = '0;
    key         = '0;
    masked      = 1'b0;
    mask_pos    = '0;
    final_frame = 1'b0;
    in_msg      = 1'b0;
    first_op    = '0;
    first_comp  = 1'b0;
    msg_bytes   = '0;
    status      = CLOSE_DEFAULT;
  endtask

  task automatic emit_word(input logic [7:0] data, input logic valid, fend, mend, err);
    wsdf_result_t w;
    w.data_byte   = data;
    w.data_valid  = valid;
    w.frame_end   = fend;
    w.message_end = mend;
    case (first_op)
      OP_TEXT:   w.message_kind = KIND_TEXT;
      OP_BINARY: w.message_kind = KIND_BINARY;
      OP_CLOSE:  w.message_kind = KIND_CLOSE;
      OP_PING:   w.message_kind = KIND_PING;
      OP_PONG:   w.message_kind = KIND_PONG;
      default:   w.message_kind = KIND_UNKNOWN;
    endcase
    w.compressed   = first_comp;
    w.close_status = '0;
    if (mend && w.message_kind == KIND_CLOSE) begin
      w.close_status = (msg_bytes >= 2'd2) ? status : CLOSE_DEFAULT;
    end
    w.length_error = err;
    if (mend) begin
      in_msg = 1'b0;
    end
    awaited_words.push_back(w);
  endtask

  // Length check happens once the key, if any, is in
  task automatic close_header();
    phase = PH_HDR0;
    if (remaining > max_len) begin
      emit_word(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    end else if (remaining == 64'd0) begin
      emit_word(8'h00, 1'b0, 1'b1, final_frame, 1'b0);
    end else begin
      phase = PH_PAYLOAD;
    end
  endtask

  task automatic end_length();
    if (masked) begin
      key_left = KEY_BYTES;
      phase    = PH_KEY;
    end else begin
      close_header();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] plain;
    logic [6:0] code;
    code = 7'(b & HDR_LEN_MASK);
    case (phase)
      PH_HDR1: begin
        masked    = (b & HDR_MASK_BIT) != 8'h00;
        key       = '0;
        mask_pos  = '0;
        remaining = 64'(code);
        if (code == LEN_EXT16 || code == LEN_EXT64) begin
          len_left  = (code == LEN_EXT16) ? EXT16_LEFT : EXT64_LEFT;
          remaining = '0;
          phase     = PH_EXTLEN;
        end else begin
          end_length();
        end
      end
      PH_EXTLEN: begin
        remaining = {remaining[55:0], b};
        if (len_left == 3'd0) begin
          end_length();
        end else begin
          len_left = len_left - 3'd1;
        end
      end
      PH_KEY: begin
        key      = {key[23:0], b};
        key_left = key_left - 3'd1;
        if (key_left == 3'd0) begin
          close_header();
        end
      end
      PH_PAYLOAD: begin
        // key byte 0 sits in bits 31..24
        plain    = b ^ key[{~mask_pos, 3'b000} +: 8];
        mask_pos = mask_pos + 2'd1;
        if (msg_bytes == 2'd0) begin
          status    = {plain, 8'h00};
          msg_bytes = 2'd1;
        end else if (msg_bytes == 2'd1) begin
          status[7:0] = plain;
          msg_bytes   = 2'd2;
        end
        remaining = remaining - 64'd1;
        if (remaining == 64'd0) begin
          phase = PH_HDR0;
        end
        emit_word(plain, 1'b1, remaining == 64'd0, (remaining == 64'd0) && final_frame,
                  1'b0);
      end
      default: begin
        // first header byte; unused phase codes land here too
        final_frame = (b & HDR_FIN_BIT) != 8'h00;
        if (!in_msg) begin
          in_msg     = 1'b1;
          first_op   = 4'(b & HDR_OPC_MASK);
          first_comp = (b & HDR_RSV1_BIT) != 8'h00;
          msg_bytes  = '0;
          status     = CLOSE_DEFAULT;
        end
        phase = PH_HDR1;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches_o++;
    end
  endtask

  // Outputs are read before this edge's register updates take effect
  always @(posedge clk_i or negedge rst_ni) begin
    wsdf_result_t want;
    if (!rst_ni) begin
      clear_parser();
      awaited_words.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_words.size() == 0) begin
          $error("result word with nothing awaited");
          mismatches_o++;
        end else begin
          want = awaited_words.pop_front();
          check_field("data_byte", 16'(want.data_byte), 16'(data_byte_o));
          check_field("data_valid", 16'(want.data_valid), 16'(data_valid_o));
          check_field("frame_end", 16'(want.frame_end), 16'(frame_end_o));
          check_field("message_end", 16'(want.message_end), 16'(message_end_o));
          check_field("message_kind", 16'(want.message_kind), 16'(message_kind_o));
          check_field("compressed", 16'(want.compressed), 16'(compressed_o));
          check_field("close_status", want.close_status, close_status_o);
          check_field("length_error", 16'(want.length_error), 16'(length_error_o));
        end
      end
      if (psel && penable && pwrite && pready && paddr[CfgAddrW-1:3] == REG_MAXLEN) begin
        max_len = pwdata;
      end
      if (rx_valid_i && rx_ready_o) begin
        deframe_byte(rx_byte_i);
      end
    end
    awaited_o = awaited_words.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the frame deframer with a short run of hand-built frames, then with
// random messages and line noise under several length limits and handshake
// idling profiles; the stream checker predicts and compares every word.
// ----------------------------------------------------------------------------
module testbench import wsdf_pkg::*;;

  localparam logic [CfgAddrW-1:0] MAXLEN_ADDR   = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] SPARE_ADDR    = CfgAddrW'(8);
  localparam logic [3:0]          OP_CONT       = 4'h0;
  localparam int                  BYTES_PER_SEG = 192;
  localparam int                  SEGMENTS      = 6;

  typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [CfgDataW-1:0] pwdata      = '0;
  logic                pready;
  logic                rx_valid_i  = 1'b0;
  logic                rx_ready_o;
  logic [7:0]          rx_byte_i   = 8'h00;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          data_byte_o;
  logic                data_valid_o;
  logic                frame_end_o;
  logic                message_end_o;
  logic [2:0]          message_kind_o;
  logic                compressed_o;
  logic [15:0]         close_status_o;
  logic                length_error_o;

  int          mismatches;
  int          awaited;
  int          snd_idle_pct = 18;
  int          rcv_idle_pct = 84;
  int          bytes_sent   = 0;
  logic [63:0] cur_max      = MAXLEN_RESET;

  websocket_frame_deframer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (),
    .pready         (pready),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_o    (data_byte_o),
    .data_valid_o   (data_valid_o),
    .frame_end_o    (frame_end_o),
    .message_end_o  (message_end_o),
    .message_kind_o (message_kind_o),
    .compressed_o   (compressed_o),
    .close_status_o (close_status_o),
    .length_error_o (length_error_o)
  );

  wsdf_stream_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_o    (data_byte_o),
    .data_valid_o   (data_valid_o),
    .frame_end_o    (frame_end_o),
    .message_end_o  (message_end_o),
    .message_kind_o (message_kind_o),
    .compressed_o   (compressed_o),
    .close_status_o (close_status_o),
    .length_error_o (length_error_o),
    .mismatches_o   (mismatches),
    .awaited_o      (awaited)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Hold the word until accepted; returns on the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic apb_write(input logic [CfgAddrW-1:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic idle_until_drained();
    rx_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited != 0);
    repeat (2) @(negedge clk_i);
  endtask

  function automatic logic [63:0] pick_length(input len_form_e form);
    logic [63:0] n;
    int          r;
    r = $urandom_range(0, 99);
    case (form)
      FORM_SHORT: n = (r < 80) ? 64'($urandom_range(0, 10)) : 64'($urandom_range(0, 125));
      FORM_EXT16: n = (r < 60) ? 64'($urandom_range(0, 20)) : 64'($urandom_range(0, 65535));
      default:    n = (r < 50) ? 64'($urandom_range(0, 20)) : {$urandom, $urandom};
    endcase
    // land on the limit and just past it
    if (r >= 92 && cur_max < 64'd120) begin
      n = cur_max + 64'(r & 1);
    end
    // keep accepted payloads short
    if (n > 64'd300 && n <= cur_max) begin
      n = n % 64'd16;
    end
    return n;
  endfunction

  task automatic send_frame(input logic [7:0] head, input len_form_e form,
                            input logic [63:0] len, input logic masked);
    logic [6:0] code;
    case (form)
      FORM_EXT16: code = LEN_EXT16;
      FORM_EXT64: code = LEN_EXT64;
      default:    code = len[6:0];
    endcase
    send_byte(head);
    send_byte({masked, code});
    if (form == FORM_EXT16) begin
      for (int i = 1; i >= 0; i--) send_byte(len[6'(8 * i) +: 8]);
    end
    if (form == FORM_EXT64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[6'(8 * i) +: 8]);
    end
    if (masked) begin
      repeat (4) send_byte(8'($urandom));
    end
    // an oversized frame is abandoned after its header
    if (len <= cur_max) begin
      repeat (int'(len)) send_byte(8'($urandom));
    end
  endtask

  task automatic send_message();
    int         frames;
    logic [3:0] op;
    logic [7:0] head;
    len_form_e  form;
    int         r;
    frames = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
    case ($urandom_range(0, 6))
      0:       op = OP_TEXT;
      1:       op = OP_BINARY;
      2:       op = OP_CLOSE;
      3:       op = OP_PING;
      4:       op = OP_PONG;
      5:       op = OP_CONT;
      default: op = 4'($urandom);
    endcase
    for (int f = 0; f < frames; f++) begin
      head = {f == frames - 1, 3'($urandom), op};
      if (f > 0) begin
        head[3:0] = ($urandom_range(0, 5) == 0) ? 4'($urandom) : OP_CONT;
      end
      r    = $urandom_range(0, 99);
      form = (r < 70) ? FORM_SHORT : (r < 85) ? FORM_EXT16 : FORM_EXT64;
      send_frame(head, form, pick_length(form), $urandom_range(0, 9) < 7);
    end
  endtask

  initial begin
    logic [7:0]  opening [$];
    logic [63:0] limit;
    int          target;
    opening = '{
      8'h81, 8'h00,                                      // empty final text frame
      8'hC8, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A,          // compressed masked close
      8'hFB, 8'hEA,                                      //   with a two-byte status
      8'h88, 8'h00,                                      // close without status
      8'h02, 8'h7E, 8'h00, 8'h01, 8'hFF,                 // binary fragment, 16-bit length
      8'h8F, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,   // final fragment, 64-bit length
      8'h00, 8'h00, 8'h01, 8'h00
    };
    target = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (opening[i]) send_byte(opening[i]);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       limit = MAXLEN_RESET;
        1:       limit = 64'd0;
        2:       limit = 64'd12;
        3:       limit = 64'd300;
        4:       limit = 64'd7;
        default: limit = 64'h8000_0000_0000_0000;
      endcase
      // reconfigure only with nothing in flight
      idle_until_drained();
      if (seg == 0) begin
        apb_write(SPARE_ADDR, {$urandom, $urandom});
      end
      apb_write(MAXLEN_ADDR, limit);
      cur_max = limit;
      case (seg / 2)
        0: begin
          snd_idle_pct = 18;
          rcv_idle_pct = 84;
        end
        1: begin
          snd_idle_pct = 84;
          rcv_idle_pct = 18;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      target += BYTES_PER_SEG;
      while (bytes_sent < target) begin
        // noise only where any length it forms stays bounded
        if (cur_max <= 64'd300 && $urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else begin
          send_message();
        end
      end
    end

    rx_valid_i <= 1'b0;
    for (int w = 0; w < 20000 && awaited != 0; w++) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && awaited == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/wsdf_pkg.sv
rtl/wsdf_cfg_regs.sv
rtl/wsdf_parser.sv
rtl/websocket_frame_deframer_unit.sv
tb/wsdf_stream_checker.sv
tb/testbench.sv
